// File: sv/vcdg_pkg.sv
// Shared types, sizes and register codes of the central difference gradient block.
package vcdg_pkg;

    // Largest volume the storage is built for
    localparam int MAX_X = 256;
    localparam int MAX_Y = 256;
    localparam int MAX_Z = 256;

    localparam int SAMPLE_W  = 8;
    localparam int CFG_W     = 9;
    localparam int CFG_IDX_W = 3;

    // Size, pair product and volume count widths
    localparam int MAX_XY   = MAX_X > MAX_Y ? MAX_X : MAX_Y;
    localparam int MAX_SIZE = MAX_XY > MAX_Z ? MAX_XY : MAX_Z;
    localparam int SIZE_W   = $clog2(MAX_SIZE + 1);

    localparam longint unsigned PAIR_XY  = longint'(MAX_X) * longint'(MAX_Y);
    localparam longint unsigned PAIR_YZ  = longint'(MAX_Y) * longint'(MAX_Z);
    localparam longint unsigned PAIR_XZ  = longint'(MAX_X) * longint'(MAX_Z);
    localparam longint unsigned PAIR_A   = PAIR_XY > PAIR_YZ ? PAIR_XY : PAIR_YZ;
    localparam longint unsigned MAX_PAIR = PAIR_A > PAIR_XZ ? PAIR_A : PAIR_XZ;
    localparam int PAIR_W = $clog2(MAX_PAIR + 1);

    localparam longint unsigned MAX_TOTAL = PAIR_XY * longint'(MAX_Z);
    localparam int CNT_W = $clog2(MAX_TOTAL + 1);

    // Delay line rings: plane segment holds X*(Y-1)-1 words, row segment X-2
    localparam int PLANE_RING = MAX_X * (MAX_Y - 1) - 1;
    localparam int ROW_RING   = MAX_X > 3 ? MAX_X - 2 : 1;
    localparam int PLANE_AW   = PLANE_RING > 1 ? $clog2(PLANE_RING) : 1;
    localparam int ROW_AW     = ROW_RING > 1 ? $clog2(ROW_RING) : 1;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_X_SIZE = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_Y_SIZE = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_Z_SIZE = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_MODE   = CFG_IDX_W'(3);

    // Opcodes
    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_DRAIN  = 1'b1;

    // Reset configuration, clamped to the built sizes
    localparam int RST_X = MAX_X < 256 ? MAX_X : 256;
    localparam int RST_Y = MAX_Y < 256 ? MAX_Y : 256;
    localparam int RST_Z = MAX_Z < 256 ? MAX_Z : 256;
    localparam logic [PAIR_W-1:0] RST_PLANE = PAIR_W'(longint'(RST_X) * longint'(RST_Y));
    localparam logic [PAIR_W-1:0] RST_YZ    = PAIR_W'(longint'(RST_Y) * longint'(RST_Z));
    localparam logic [PAIR_W-1:0] RST_XZ    = PAIR_W'(longint'(RST_X) * longint'(RST_Z));
    localparam logic [CNT_W-1:0]  RST_TOTAL =
        CNT_W'(longint'(RST_X) * longint'(RST_Y) * longint'(RST_Z));

    typedef struct packed {
        logic                       opcode;
        logic signed [SAMPLE_W-1:0] sample;
    } t_item;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] voxel_value;
        logic signed [SAMPLE_W-1:0] grad_x;
        logic signed [SAMPLE_W-1:0] grad_y;
        logic signed [SAMPLE_W-1:0] grad_z;
        logic                       last;
    } t_result;

    // Stencil taps around the center voxel r
    typedef struct packed {
        logic signed [SAMPLE_W-1:0] plus_z;
        logic signed [SAMPLE_W-1:0] plus_y;
        logic signed [SAMPLE_W-1:0] plus_x;
        logic signed [SAMPLE_W-1:0] center;
        logic signed [SAMPLE_W-1:0] minus_x;
        logic signed [SAMPLE_W-1:0] minus_y;
        logic signed [SAMPLE_W-1:0] minus_z;
    } t_taps;

    // Result request with edge flags for the stencil stage
    typedef struct packed {
        logic valid;
        logic pass;
        logic last;
        logic lo_x;
        logic lo_y;
        logic lo_z;
        logic hi_x;
        logic hi_y;
        logic hi_z;
    } t_issue;

    // Clamp a written size into [2, hi]
    function automatic logic [SIZE_W-1:0] clamp_size(logic [CFG_W-1:0] v, int hi);
        int val;
        val = int'(v);
        if (val < 2) begin
            val = 2;
        end else if (val > hi) begin
            val = hi;
        end
        return SIZE_W'(val);
    endfunction

endpackage

// File: sv/vcdg_ram.sv
// Generic simple dual port RAM with registered, enabled read.
module vcdg_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2,
    localparam int AW   = DEPTH > 1 ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Read old contents first, then write
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: sv/vcdg_window.sv
// Sample delay line with fixed stencil taps built from plane and row rings.
module vcdg_window (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_restart,
    input  logic                          i_shift,
    input  logic [vcdg_pkg::SAMPLE_W-1:0] i_din,
    input  logic [vcdg_pkg::SIZE_W-1:0]   i_xs,
    input  logic [vcdg_pkg::PAIR_W-1:0]   i_plane,
    output vcdg_pkg::t_taps               o_taps
);
    import vcdg_pkg::*;

    logic [PLANE_AW-1:0] r_pp;
    logic [ROW_AW-1:0]   r_rp;
    logic [PAIR_W-1:0]   plane_last;
    logic [SIZE_W-1:0]   row_last;
    logic                row_zero;

    logic [SAMPLE_W-1:0] r_t0;
    logic [SAMPLE_W-1:0] r_t3;
    logic [SAMPLE_W-1:0] r_t4;
    logic [SAMPLE_W-1:0] r_byp1;
    logic [SAMPLE_W-1:0] r_byp2;
    logic [SAMPLE_W-1:0] q_p1;
    logic [SAMPLE_W-1:0] q_r1;
    logic [SAMPLE_W-1:0] q_r2;
    logic [SAMPLE_W-1:0] q_p2;
    logic [SAMPLE_W-1:0] t2;
    logic [SAMPLE_W-1:0] t5;

    // Ring ends: plane segment X*Y-X-1 words, row segment X-2 words
    assign plane_last = i_plane - PAIR_W'(i_xs) - PAIR_W'(2);
    assign row_last   = i_xs - SIZE_W'(3);
    assign row_zero   = (i_xs == SIZE_W'(2));

    // Advance ring pointers on each shift
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_restart) begin
            r_pp <= '0;
            r_rp <= '0;
        end else if (i_shift) begin
            if (r_pp == plane_last[PLANE_AW-1:0]) begin
                r_pp <= '0;
            end else begin
                r_pp <= r_pp + PLANE_AW'(1);
            end
            if (row_zero || r_rp == row_last[ROW_AW-1:0]) begin
                r_rp <= '0;
            end else begin
                r_rp <= r_rp + ROW_AW'(1);
            end
        end
    end

    // Shift the register taps and the bypass stages for the shortest rows
    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_t0   <= i_din;
            r_byp1 <= q_p1;
            r_t3   <= t2;
            r_t4   <= r_t3;
            r_byp2 <= r_t4;
        end
    end

    assign t2 = row_zero ? r_byp1 : q_r1;
    assign t5 = row_zero ? r_byp2 : q_r2;

    vcdg_ram #(.WIDTH(SAMPLE_W), .DEPTH(PLANE_RING)) u_plane_hi (
        .i_clk   (i_clk),
        .i_we    (i_shift),
        .i_waddr (r_pp),
        .i_wdata (r_t0),
        .i_re    (i_shift),
        .i_raddr (r_pp),
        .o_rdata (q_p1)
    );

    vcdg_ram #(.WIDTH(SAMPLE_W), .DEPTH(ROW_RING)) u_row_hi (
        .i_clk   (i_clk),
        .i_we    (i_shift),
        .i_waddr (r_rp),
        .i_wdata (q_p1),
        .i_re    (i_shift),
        .i_raddr (r_rp),
        .o_rdata (q_r1)
    );

    vcdg_ram #(.WIDTH(SAMPLE_W), .DEPTH(ROW_RING)) u_row_lo (
        .i_clk   (i_clk),
        .i_we    (i_shift),
        .i_waddr (r_rp),
        .i_wdata (r_t4),
        .i_re    (i_shift),
        .i_raddr (r_rp),
        .o_rdata (q_r2)
    );

    vcdg_ram #(.WIDTH(SAMPLE_W), .DEPTH(PLANE_RING)) u_plane_lo (
        .i_clk   (i_clk),
        .i_we    (i_shift),
        .i_waddr (r_pp),
        .i_wdata (t5),
        .i_re    (i_shift),
        .i_raddr (r_pp),
        .o_rdata (q_p2)
    );

    // Taps relative to the newest sample n: center is n - X*Y
    assign o_taps.plus_z  = r_t0;
    assign o_taps.plus_y  = q_p1;
    assign o_taps.plus_x  = t2;
    assign o_taps.center  = r_t3;
    assign o_taps.minus_x = r_t4;
    assign o_taps.minus_y = t5;
    assign o_taps.minus_z = q_p2;

endmodule

// File: sv/vcdg_ctrl.sv
// Configuration registers, volume counters and result issue with edge flags.
module vcdg_ctrl (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    input  vcdg_pkg::t_item                i_item,
    input  logic                           i_cfg_we,
    input  logic [vcdg_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [vcdg_pkg::CFG_W-1:0]     i_cfg_data,
    input  logic                           i_out_free,
    output logic                           o_in_stall,
    output logic                           o_shift,
    output logic                           o_restart,
    output logic [vcdg_pkg::SIZE_W-1:0]    o_xs,
    output logic [vcdg_pkg::PAIR_W-1:0]    o_plane,
    output vcdg_pkg::t_issue               o_issue
);
    import vcdg_pkg::*;

    logic [SIZE_W-1:0] r_xs;
    logic [SIZE_W-1:0] r_ys;
    logic [SIZE_W-1:0] r_zs;
    logic              r_mode;
    logic [PAIR_W-1:0] r_plane;
    logic [PAIR_W-1:0] r_yz;
    logic [PAIR_W-1:0] r_xz;
    logic [CNT_W-1:0]  r_total;
    logic [CNT_W-1:0]  r_taken;
    logic [CNT_W-1:0]  r_given;
    logic [CNT_W-1:0]  n_taken;
    logic [CNT_W-1:0]  n_given;
    t_issue            r_s1;
    t_issue            n_issue;

    logic              cfg_hit;
    logic [SIZE_W-1:0] wr_size;
    logic              accept;
    logic              is_sample;
    logic              room;
    logic              store;
    logic              flush;
    logic [CNT_W:0]    given_ext;
    logic [CNT_W:0]    total_ext;

    function automatic logic [PAIR_W-1:0] pair_mul(logic [SIZE_W-1:0] a, logic [SIZE_W-1:0] b);
        logic [2*SIZE_W-1:0] p;
        p = a * b;
        return p[PAIR_W-1:0];
    endfunction

    function automatic logic [CNT_W-1:0] vol_mul(logic [SIZE_W-1:0] a, logic [PAIR_W-1:0] b);
        logic [SIZE_W+PAIR_W-1:0] p;
        p = a * b;
        return p[CNT_W-1:0];
    endfunction

    assign wr_size = clamp_size(i_cfg_data,
        (i_cfg_idx == REG_X_SIZE) ? MAX_X : ((i_cfg_idx == REG_Y_SIZE) ? MAX_Y : MAX_Z));

    // Known register indexes restart the volume
    always_comb begin
        case (i_cfg_idx)
            REG_X_SIZE, REG_Y_SIZE, REG_Z_SIZE, REG_MODE: cfg_hit = i_cfg_we;
            default:                                      cfg_hit = 1'b0;
        endcase
    end

    // Write configuration; keep the pair and volume products current
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_xs    <= SIZE_W'(RST_X);
            r_ys    <= SIZE_W'(RST_Y);
            r_zs    <= SIZE_W'(RST_Z);
            r_mode  <= 1'b1;
            r_plane <= RST_PLANE;
            r_yz    <= RST_YZ;
            r_xz    <= RST_XZ;
            r_total <= RST_TOTAL;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_X_SIZE: begin
                    r_xs    <= wr_size;
                    r_plane <= pair_mul(wr_size, r_ys);
                    r_xz    <= pair_mul(wr_size, r_zs);
                    r_total <= vol_mul(wr_size, r_yz);
                end
                REG_Y_SIZE: begin
                    r_ys    <= wr_size;
                    r_plane <= pair_mul(r_xs, wr_size);
                    r_yz    <= pair_mul(wr_size, r_zs);
                    r_total <= vol_mul(wr_size, r_xz);
                end
                REG_Z_SIZE: begin
                    r_zs    <= wr_size;
                    r_yz    <= pair_mul(r_ys, wr_size);
                    r_xz    <= pair_mul(r_xs, wr_size);
                    r_total <= vol_mul(wr_size, r_plane);
                end
                REG_MODE: begin
                    r_mode <= i_cfg_data[0];
                end
                default: begin
                end
            endcase
        end
    end

    // Decide storage, delay line shift and result issue for the word
    assign o_in_stall = r_s1.valid && !i_out_free;
    assign accept     = i_in_valid && !o_in_stall;
    assign is_sample  = (i_item.opcode == OP_SAMPLE);
    assign room       = (r_taken != r_total);
    assign store      = accept && is_sample && room;
    assign flush      = accept && !is_sample && !room && r_mode;
    assign given_ext  = {1'b0, r_given};
    assign total_ext  = {1'b0, r_total};

    always_comb begin
        n_issue.pass  = !r_mode;
        n_issue.valid = r_mode ? ((store && r_taken >= CNT_W'(r_plane)) || flush) : store;
        n_issue.last  = (given_ext + (CNT_W+1)'(1) == total_ext);
        n_issue.lo_x  = (r_given == '0);
        n_issue.lo_y  = (r_given < CNT_W'(r_xs));
        n_issue.lo_z  = (r_given < CNT_W'(r_plane));
        n_issue.hi_x  = (given_ext + (CNT_W+1)'(1) >= total_ext);
        n_issue.hi_y  = (given_ext + (CNT_W+1)'(r_xs) >= total_ext);
        n_issue.hi_z  = (given_ext + (CNT_W+1)'(r_plane) >= total_ext);
    end

    // Count stored samples and issued results; drop both at volume end or on a known register write
    always_comb begin
        n_taken = r_taken + CNT_W'(store);
        n_given = r_given + CNT_W'(n_issue.valid);
        if (cfg_hit || (n_issue.valid && n_issue.last)) begin
            n_taken = '0;
            n_given = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_taken <= '0;
            r_given <= '0;
        end else begin
            r_taken <= n_taken;
            r_given <= n_given;
        end
    end

    // Hold the issued request until the result register takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1 <= '0;
        end else if (accept) begin
            r_s1 <= n_issue;
        end else if (i_out_free) begin
            r_s1.valid <= 1'b0;
        end
    end

    assign o_shift   = store || flush;
    assign o_restart = cfg_hit;
    assign o_xs      = r_xs;
    assign o_plane   = r_plane;
    assign o_issue   = r_s1;

`ifndef SYNTHESIS
    a_given_le_taken: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_given <= r_taken)
        else $error("results issued exceed samples stored");

    a_taken_le_total: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_taken <= r_total)
        else $error("samples stored exceed volume size");

    a_last_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && n_issue.valid && n_issue.last) |=> (r_taken == '0 && r_given == '0))
        else $error("counters not cleared after final voxel");

    a_pass_in_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_mode |-> (r_taken == r_given))
        else $error("pass-through mode left a sample pending");
`endif

endmodule

// File: sv/vcdg_stencil.sv
// Edge selection, half differences and the result register.
module vcdg_stencil (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  vcdg_pkg::t_issue  i_issue,
    input  vcdg_pkg::t_taps   i_taps,
    input  logic              i_out_stall,
    output logic              o_out_free,
    output logic              o_out_valid,
    output vcdg_pkg::t_result o_result
);
    import vcdg_pkg::*;

    logic    r_valid;
    t_result r_result;
    t_result n_result;

    // (plus - minus) / 2 truncated toward zero
    function automatic logic [SAMPLE_W-1:0] half_diff(logic signed [SAMPLE_W-1:0] plus,
                                                      logic signed [SAMPLE_W-1:0] minus);
        logic signed [SAMPLE_W:0] d;
        logic signed [SAMPLE_W:0] adj;
        d   = {plus[SAMPLE_W-1], plus} - {minus[SAMPLE_W-1], minus};
        adj = d + {{SAMPLE_W{1'b0}}, d[SAMPLE_W]};
        return adj[SAMPLE_W:1];
    endfunction

    // Out-of-volume taps take the center; pass mode zeros gradients
    always_comb begin
        n_result.last = i_issue.last;
        if (i_issue.pass) begin
            n_result.voxel_value = i_taps.plus_z;
            n_result.grad_x      = '0;
            n_result.grad_y      = '0;
            n_result.grad_z      = '0;
        end else begin
            n_result.voxel_value = i_taps.center;
            n_result.grad_x = half_diff(i_issue.hi_x ? i_taps.center : i_taps.plus_x,
                                        i_issue.lo_x ? i_taps.center : i_taps.minus_x);
            n_result.grad_y = half_diff(i_issue.hi_y ? i_taps.center : i_taps.plus_y,
                                        i_issue.lo_y ? i_taps.center : i_taps.minus_y);
            n_result.grad_z = half_diff(i_issue.hi_z ? i_taps.center : i_taps.plus_z,
                                        i_issue.lo_z ? i_taps.center : i_taps.minus_z);
        end
    end

    assign o_out_free = !r_valid || !i_out_stall;

    // Load the result register whenever it is empty or being taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_out_free) begin
            r_valid <= i_issue.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_out_free && i_issue.valid) begin
            r_result <= n_result;
        end
    end

    assign o_out_valid = r_valid;
    assign o_result    = r_result;

endmodule

// File: sv/volume_central_difference_gradient.sv
// Top level of the streaming 3D central difference gradient block.
// Samples stream in x-fastest linear order, one word per cycle with no gaps
// needed while the output does not stall. In gradient mode the result for
// voxel r leaves once sample r + X*Y is taken (X*Y+1 words of lag), via the
// tap and result registers; drain words then flush the last X*Y results, one
// per cycle while unstalled. The lag comes from the sample delay line: two
// plane rings and two row rings in RAM, which need no clearing pass because
// taps outside the current volume are replaced by the center sample. Size and
// mode writes restart the volume and must be issued while the block is idle.
module volume_central_difference_gradient (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  vcdg_pkg::t_item                i_item,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output vcdg_pkg::t_result              o_result,
    input  logic                           i_cfg_we,
    input  logic [vcdg_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [vcdg_pkg::CFG_W-1:0]     i_cfg_data
);
    import vcdg_pkg::*;

    logic              out_free;
    logic              shift;
    logic              restart;
    logic [SIZE_W-1:0] xs;
    logic [PAIR_W-1:0] plane;
    t_issue            issue;
    t_taps             taps;

    vcdg_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_item     (i_item),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_out_free (out_free),
        .o_in_stall (o_in_stall),
        .o_shift    (shift),
        .o_restart  (restart),
        .o_xs       (xs),
        .o_plane    (plane),
        .o_issue    (issue)
    );

    vcdg_window u_window (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_restart (restart),
        .i_shift   (shift),
        .i_din     (i_item.sample),
        .i_xs      (xs),
        .i_plane   (plane),
        .o_taps    (taps)
    );

    vcdg_stencil u_stencil (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_issue     (issue),
        .i_taps      (taps),
        .i_out_stall (i_out_stall),
        .o_out_free  (out_free),
        .o_out_valid (o_out_valid),
        .o_result    (o_result)
    );

endmodule

// File: sim/volume_central_difference_gradient_tb.sv
// Self-checking testbench for the streaming 3D central difference gradient block.
module volume_central_difference_gradient_tb;
    import vcdg_pkg::*;

    localparam int HALF_PERIOD    = 6;
    localparam int RESET_CYCLES   = 11;
    localparam int IDLE_PCT       = 21;
    localparam int RANDOM_ITEMS   = 650;
    localparam int SETTLE_CYCLES  = 16;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int MAX_REPORTS    = 40;
    localparam int VOL_RING       = 2 * MAX_X * MAX_Y + 1;

    // Indexes that decode to no register
    localparam logic [CFG_IDX_W-1:0] REG_NONE_FIRST = CFG_IDX_W'(4);
    localparam logic [CFG_IDX_W-1:0] REG_NONE_LAST  = CFG_IDX_W'(7);

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 in_valid  = 1'b0;
    logic                 in_stall;
    t_item                in_item   = '0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    t_result              out_result;
    logic                 cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_idx   = '0;
    logic [CFG_W-1:0]     cfg_data  = '0;

    // Stimulus side
    t_item       pending_items[$];
    bit          item_taken    = 1'b0;
    int          src_idle_pct  = IDLE_PCT;
    int          sink_idle_pct = IDLE_PCT;
    int unsigned vol_plane;
    int unsigned vol_total;
    bit          vol_mode;

    // Gradient predictor state
    logic signed [SAMPLE_W-1:0] voxel_ring[VOL_RING];
    int unsigned                n_taken;
    int unsigned                n_given;
    logic [CFG_W-1:0]           size_x_reg;
    logic [CFG_W-1:0]           size_y_reg;
    logic [CFG_W-1:0]           size_z_reg;
    logic                       mode_reg;
    t_result                    expected_voxels[$];

    // Run statistics
    int unsigned mismatch_count  = 0;
    int unsigned items_accepted  = 0;
    int unsigned results_checked = 0;
    int unsigned volumes_done    = 0;
    int unsigned reg_writes      = 0;
    int unsigned quiet_cycles    = 0;

    volume_central_difference_gradient DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_item      (in_item),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_result    (out_result),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data)
    );

    always begin
        #(HALF_PERIOD) clk = ~clk;
    end

    // Clamp a size register into [2, hi]
    function automatic int unsigned bounded_size(int unsigned v, int unsigned hi);
        int unsigned w;
        w = v & 32'h1FF;
        if (w < 2) begin
            return 2;
        end
        return (w > hi) ? hi : w;
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] ring_at(int unsigned idx);
        return voxel_ring[idx % VOL_RING];
    endfunction

    // Half difference over linear step s, edges replaced by the center voxel
    function automatic logic signed [SAMPLE_W-1:0] half_step(int unsigned i, int unsigned s,
                                                             int unsigned total);
        int lo;
        int hi;
        int d;
        lo = (s > i) ? int'(ring_at(i)) : int'(ring_at(i - s));
        hi = (i + s >= total) ? int'(ring_at(i)) : int'(ring_at(i + s));
        d  = (hi - lo) / 2;
        return d[SAMPLE_W-1:0];
    endfunction

    function automatic void apply_reg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
        case (idx)
            REG_X_SIZE: size_x_reg = data;
            REG_Y_SIZE: size_y_reg = data;
            REG_Z_SIZE: size_z_reg = data;
            REG_MODE:   mode_reg = data[0];
            default:    return;
        endcase
        n_taken = 0;
        n_given = 0;
    endfunction

    // Advance the predictor by one word; return 1 when it yields a voxel
    function automatic bit predict_voxel(input t_item it, output t_result res);
        int unsigned xs;
        int unsigned plane;
        int unsigned total;
        int unsigned r;
        res   = '0;
        xs    = bounded_size(size_x_reg, MAX_X);
        plane = xs * bounded_size(size_y_reg, MAX_Y);
        total = plane * bounded_size(size_z_reg, MAX_Z);
        if (it.opcode == OP_SAMPLE) begin
            if (n_taken >= total) begin
                return 0;
            end
            voxel_ring[n_taken % VOL_RING] = it.sample;
            n_taken++;
        end
        r = n_given;
        if (r >= n_taken) begin
            return 0;
        end
        res.voxel_value = ring_at(r);
        if (mode_reg) begin
            if (!(n_taken == total || r + plane < n_taken)) begin
                return 0;
            end
            res.grad_x = half_step(r, 1, total);
            res.grad_y = half_step(r, xs, total);
            res.grad_z = half_step(r, plane, total);
        end
        res.last = (r + 1 == total);
        n_given++;
        if (res.last) begin
            n_taken = 0;
            n_given = 0;
        end
        return 1;
    endfunction

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS) begin
            $display("MISMATCH at result %0d: %s", results_checked, msg);
        end
    endtask

    task automatic check_field(input string name, input int got, input int want);
        if (got != want) begin
            report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
        end
    endtask

    // Hold a word until it is taken, then load the next one or idle
    always @(negedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else if (!in_valid || item_taken) begin
            if (pending_items.size() != 0 && $urandom_range(0, 99) >= src_idle_pct) begin
                in_item  <= pending_items.pop_front();
                in_valid <= 1'b1;
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // Stall the result side at random
    always @(negedge clk) begin
        if (!rst_n) begin
            out_stall <= 1'b0;
        end else begin
            out_stall <= ($urandom_range(0, 99) < sink_idle_pct);
        end
    end

    // Predict on accepted words, check accepted results, watch for a hang
    always @(posedge clk) begin
        t_result want;
        t_result got;
        bit      active;
        item_taken = rst_n && in_valid && !in_stall;
        if (!rst_n) begin
            n_taken    = 0;
            n_given    = 0;
            size_x_reg = CFG_W'(256);
            size_y_reg = CFG_W'(256);
            size_z_reg = CFG_W'(256);
            mode_reg   = 1'b1;
        end else begin
            active = item_taken || cfg_we;
            if (cfg_we) begin
                apply_reg_write(cfg_idx, cfg_data);
            end
            if (item_taken) begin
                items_accepted++;
                if (predict_voxel(in_item, want)) begin
                    expected_voxels.push_back(want);
                end
            end
            if (out_valid && !out_stall) begin
                active = 1'b1;
                got    = out_result;
                if (got.last) begin
                    volumes_done++;
                end
                if (expected_voxels.size() == 0) begin
                    report_mismatch("result arrived with none pending");
                end else begin
                    want = expected_voxels.pop_front();
                    check_field("voxel_value", got.voxel_value, want.voxel_value);
                    check_field("grad_x", got.grad_x, want.grad_x);
                    check_field("grad_y", got.grad_y, want.grad_y);
                    check_field("grad_z", got.grad_z, want.grad_z);
                    check_field("last", got.last, want.last);
                end
                results_checked++;
            end
            quiet_cycles = active ? 0 : quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("TIMEOUT: no word moved for %0d cycles", WATCHDOG_LIMIT);
                $display("volume_central_difference_gradient test failed");
                $finish;
            end
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned value);
        @(negedge clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= CFG_W'(value);
        @(negedge clk);
        cfg_we   <= 1'b0;
        reg_writes++;
    endtask

    // Write all four registers and note the resulting volume shape
    task automatic set_volume(input int unsigned x, input int unsigned y, input int unsigned z,
                              input bit mode, input bit shuffle);
        logic [CFG_IDX_W-1:0] order[4];
        logic [CFG_IDX_W-1:0] tmp;
        int                   j;
        order = '{REG_X_SIZE, REG_Y_SIZE, REG_Z_SIZE, REG_MODE};
        if (shuffle) begin
            for (int k = 3; k > 0; k--) begin
                j        = $urandom_range(0, k);
                tmp      = order[k];
                order[k] = order[j];
                order[j] = tmp;
            end
        end
        for (int k = 0; k < 4; k++) begin
            case (order[k])
                REG_X_SIZE: write_reg(REG_X_SIZE, x);
                REG_Y_SIZE: write_reg(REG_Y_SIZE, y);
                REG_Z_SIZE: write_reg(REG_Z_SIZE, z);
                default:    write_reg(REG_MODE, mode);
            endcase
        end
        vol_plane = bounded_size(x, MAX_X) * bounded_size(y, MAX_Y);
        vol_total = vol_plane * bounded_size(z, MAX_Z);
        vol_mode  = mode;
    endtask

    task automatic push_sample(input logic signed [SAMPLE_W-1:0] v);
        t_item it;
        it.opcode = OP_SAMPLE;
        it.sample = v;
        pending_items.push_back(it);
    endtask

    task automatic push_drain();
        t_item it;
        it.opcode = OP_DRAIN;
        it.sample = SAMPLE_W'($urandom_range(0, 255));
        pending_items.push_back(it);
    endtask

    function automatic logic signed [SAMPLE_W-1:0] rand_sample();
        case ($urandom_range(0, 19))
            0:       return -8'sd128;
            1:       return 8'sd127;
            2:       return 8'sd0;
            3:       return -8'sd1;
            default: return SAMPLE_W'($urandom_range(0, 255));
        endcase
    endfunction

    // Queue samples, with a stray drain now and then when noisy
    task automatic push_samples(input int unsigned count, input bit noisy);
        repeat (count) begin
            if (noisy && $urandom_range(0, 24) == 0) begin
                push_drain();
            end
            push_sample(rand_sample());
        end
    endtask

    // In gradient mode, flush the last plane of results; extra samples here must be dropped
    task automatic push_tail(input bit noisy);
        if (vol_mode) begin
            if (noisy && $urandom_range(0, 7) == 0) begin
                repeat ($urandom_range(1, 2)) push_sample(rand_sample());
            end
            repeat (vol_plane) push_drain();
            if (noisy && $urandom_range(0, 5) == 0) begin
                push_drain();
            end
        end
    endtask

    // Wait until every word is taken and every result is back, then settle
    task automatic wait_idle();
        do begin
            while (pending_items.size() != 0 || in_valid || expected_voxels.size() != 0) begin
                @(negedge clk);
            end
            repeat (SETTLE_CYCLES) @(negedge clk);
        end while (pending_items.size() != 0 || in_valid || expected_voxels.size() != 0);
    endtask

    initial begin
        int unsigned random_items;
        int unsigned xs;
        int unsigned ys;
        int unsigned zs;
        int unsigned nvol;
        int unsigned cut_at;
        int unsigned pick;
        random_items = 0;
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Small volume: extremes, odd differences, an ignored write mid-volume,
        // a dropped extra sample and drains with nothing pending
        set_volume(3, 2, 2, 1, 0);
        push_drain();
        push_sample(8'sd127);
        push_sample(-8'sd128);
        push_sample(8'sd127);
        push_sample(-8'sd128);
        push_sample(8'sd0);
        wait_idle();
        write_reg(REG_NONE_LAST, 9'h1FF);
        push_sample(-8'sd1);
        push_sample(8'sd1);
        push_sample(-8'sd1);
        push_sample(8'sd0);
        push_sample(8'sd3);
        push_sample(-8'sd4);
        push_sample(8'sd127);
        push_sample(-8'sd77);
        repeat (6) push_drain();
        push_drain();
        wait_idle();

        // Pass-through: results at once, drains give nothing
        write_reg(REG_MODE, 0);
        push_sample(-8'sd128);
        push_drain();
        push_sample(8'sd127);
        push_sample(8'sd0);
        wait_idle();

        // Whole volume and its drain with no idling on either side
        src_idle_pct  = 0;
        sink_idle_pct = 0;
        set_volume(8, 4, 3, 1, 0);
        push_samples(vol_total, 0);
        push_tail(0);
        wait_idle();
        src_idle_pct  = IDLE_PCT;
        sink_idle_pct = IDLE_PCT;

        // Low sizes clamped up to two
        set_volume(0, 3, 1, 1, 0);
        push_samples(vol_total, 0);
        push_tail(0);
        wait_idle();

        // Random small volumes, mostly complete, some cut short or paused
        while (random_items < RANDOM_ITEMS) begin
            xs = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1) : $urandom_range(2, 6);
            ys = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1) : $urandom_range(2, 5);
            zs = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1) : $urandom_range(2, 4);
            set_volume(xs, ys, zs, $urandom_range(0, 3) != 0, 1);
            nvol = $urandom_range(1, 3);
            for (int v = 0; v < nvol; v++) begin
                pick   = $urandom_range(0, 9);
                cut_at = $urandom_range(1, vol_total - 1);
                if (pick == 0 && v == nvol - 1) begin
                    push_samples(cut_at, 1);
                    random_items += cut_at;
                end else begin
                    if (pick == 1) begin
                        push_samples(cut_at, 1);
                        wait_idle();
                        write_reg(CFG_IDX_W'($urandom_range(REG_NONE_FIRST, REG_NONE_LAST)),
                                  $urandom_range(0, 511));
                        push_samples(vol_total - cut_at, 1);
                    end else begin
                        push_samples(vol_total, 1);
                    end
                    push_tail(1);
                    random_items += vol_total + (vol_mode ? vol_plane : 0);
                end
            end
            wait_idle();
        end

        wait_idle();
        $display("Covered %0d words in, %0d results checked, %0d volumes closed",
                 items_accepted, results_checked, volumes_done);
        $display("Register writes: %0d, mismatches: %0d", reg_writes, mismatch_count);
        if (mismatch_count == 0) begin
            $display("volume_central_difference_gradient test passed");
        end else begin
            $display("volume_central_difference_gradient test failed");
        end
        $finish;
    end

endmodule

// File: files.f
sv/vcdg_pkg.sv
sv/vcdg_ram.sv
sv/vcdg_window.sv
sv/vcdg_ctrl.sv
sv/vcdg_stencil.sv
sv/volume_central_difference_gradient.sv
sim/volume_central_difference_gradient_tb.sv
